>>> rtl/core/amo_pkg.sv
// Shared types and codes for the atomic memory operation unit.
// No dependencies; imported by the controller, the datapath and the top level.
package amo_pkg;

  localparam logic [3:0] CMD_SWAP = 4'd0;
  localparam logic [3:0] CMD_CAS  = 4'd1;
  localparam logic [3:0] CMD_ADD  = 4'd2;
  localparam logic [3:0] CMD_SUB  = 4'd3;
  localparam logic [3:0] CMD_AND  = 4'd4;
  localparam logic [3:0] CMD_OR   = 4'd5;
  localparam logic [3:0] CMD_XOR  = 4'd6;
  localparam logic [3:0] CMD_SMAX = 4'd7;
  localparam logic [3:0] CMD_SMIN = 4'd8;
  localparam logic [3:0] CMD_UMAX = 4'd9;
  localparam logic [3:0] CMD_UMIN = 4'd10;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISALIGN = 2'd1;
  localparam logic [1:0] ST_BAD_SIZE = 2'd2;
  localparam logic [1:0] ST_BAD_CMD  = 2'd3;

  localparam logic [3:0] SIZE_1 = 4'd1;
  localparam logic [3:0] SIZE_2 = 4'd2;
  localparam logic [3:0] SIZE_4 = 4'd4;
  localparam logic [3:0] SIZE_8 = 4'd8;

  typedef struct packed {
    logic [3:0]  command;
    logic [11:0] address;
    logic [3:0]  size_bytes;
    logic [63:0] operand;
    logic [63:0] expected;
  } amo_req_t;

  typedef struct packed {
    logic [63:0] result;
    logic [1:0]  status;
  } amo_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic clear;
  } amo_ctl_t;

endpackage

>>> rtl/core/amo_ctrl.sv
// Controller for the atomic memory operation unit: clear sweep, idle, execute.
// Depends on amo_pkg.
module amo_ctrl #(
  parameter int MEM_WORDS = 512,
  parameter int IDX_W     = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output amo_pkg::amo_ctl_t ctl,
  output logic [IDX_W-1:0] clear_idx
);
  import amo_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] clr_idx_r, clr_idx_nxt;
  logic             busy_r, busy_nxt;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MEM_WORDS - 1);

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    case (state_r)
      S_CLEAR: begin
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_idx_r <= '0;
      busy_r    <= 1'b1;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      busy_r    <= busy_nxt;
    end
  end

  assign busy      = busy_r;
  assign clear_idx = clr_idx_r;
  assign ctl.load  = start && !busy_r;
  assign ctl.exec  = (state_r == S_EXEC);
  assign ctl.clear = (state_r == S_CLEAR);

endmodule

>>> rtl/core/amo_dp.sv
// Datapath for the atomic memory operation unit: request checks, word memory,
// read-modify-write logic and the result register. Depends on amo_pkg.
module amo_dp #(
  parameter int MEM_WORDS = 512,
  parameter int IDX_W     = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  amo_pkg::amo_ctl_t ctl,
  input  logic [IDX_W-1:0]  clear_idx,
  input  amo_pkg::amo_req_t in_req,
  output logic              out_valid,
  output amo_pkg::amo_rsp_t out_rsp
);
  import amo_pkg::*;

  // Word index of a word address (byte address bits 11:3), wrapped modulo the memory depth.
  function automatic logic [IDX_W-1:0] word_index(input logic [8:0] w);
    logic [8:0] v;
    v = w;
    for (int k = 8; k >= 0; k--) begin
      if (32'(v) >= (MEM_WORDS << k)) begin
        v = v - 9'(MEM_WORDS << k);
      end
    end
    return IDX_W'(v);
  endfunction

  logic [63:0] mem [MEM_WORDS];

  amo_req_t         req_r;
  logic [1:0]       status_r;
  logic [IDX_W-1:0] idx_r;
  logic [63:0]      rd_word_r;
  logic             valid_r;
  amo_rsp_t         rsp_r;

  logic [1:0]  status_in;
  logic        size_ok;

  always_comb begin
    size_ok = (in_req.size_bytes == SIZE_1) || (in_req.size_bytes == SIZE_2) ||
              (in_req.size_bytes == SIZE_4) || (in_req.size_bytes == SIZE_8);
    if (!size_ok) begin
      status_in = ST_BAD_SIZE;
    end else if ((in_req.address[3:0] & (in_req.size_bytes - 4'd1)) != 4'd0) begin
      status_in = ST_MISALIGN;
    end else if (in_req.command > CMD_UMIN) begin
      status_in = ST_BAD_CMD;
    end else begin
      status_in = ST_OK;
    end
  end

  // Execute-cycle operand alignment and operation.
  logic [63:0] mask, sign_bit, old_val, v_val, e_val, next_val, res_val, new_word;
  logic [5:0]  shift;
  logic        s_lt_ov, s_lt_vo;

  always_comb begin
    case (req_r.size_bytes)
      SIZE_1:  mask = 64'h0000_0000_0000_00FF;
      SIZE_2:  mask = 64'h0000_0000_0000_FFFF;
      SIZE_4:  mask = 64'h0000_0000_FFFF_FFFF;
      default: mask = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    sign_bit = mask ^ (mask >> 1);
    shift    = {req_r.address[2:0], 3'b000};
    old_val  = (rd_word_r >> shift) & mask;
    v_val    = req_r.operand & mask;
    e_val    = req_r.expected & mask;
    // flip the sign bit to compare signed values as unsigned
    s_lt_ov  = (old_val ^ sign_bit) < (v_val ^ sign_bit);
    s_lt_vo  = (v_val ^ sign_bit) < (old_val ^ sign_bit);
    res_val  = old_val;
    case (req_r.command)
      CMD_SWAP: next_val = v_val;
      CMD_CAS: begin
        if (old_val == e_val) begin
          next_val = v_val;
          res_val  = 64'd0;
        end else begin
          next_val = old_val;
          res_val  = 64'd1;
        end
      end
      CMD_ADD:  next_val = old_val + v_val;
      CMD_SUB:  next_val = old_val - v_val;
      CMD_AND:  next_val = old_val & v_val;
      CMD_OR:   next_val = old_val | v_val;
      CMD_XOR:  next_val = old_val ^ v_val;
      CMD_SMAX: begin
        next_val = s_lt_ov ? v_val : old_val;
        res_val  = next_val;
      end
      CMD_SMIN: begin
        next_val = s_lt_vo ? v_val : old_val;
        res_val  = next_val;
      end
      CMD_UMAX: begin
        next_val = (v_val > old_val) ? v_val : old_val;
        res_val  = next_val;
      end
      default: begin
        next_val = (v_val < old_val) ? v_val : old_val;
        res_val  = next_val;
      end
    endcase
    next_val = next_val & mask;
    res_val  = res_val & mask;
    new_word = (rd_word_r & ~(mask << shift)) | (next_val << shift);
  end

  // Memory: read at request load, write at execute or during the clear sweep.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      mem[clear_idx] <= 64'd0;
    end else if (ctl.exec && (status_r == ST_OK)) begin
      mem[idx_r] <= new_word;
    end
    if (ctl.load) begin
      rd_word_r <= mem[word_index(in_req.address[11:3])];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_r    <= in_req;
      status_r <= status_in;
      idx_r    <= word_index(in_req.address[11:3]);
    end
    if (ctl.exec) begin
      rsp_r.status <= status_r;
      rsp_r.result <= (status_r == ST_OK) ? res_val : 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl.exec;
    end
  end

  assign out_valid = valid_r;
  assign out_rsp   = rsp_r;

endmodule

>>> rtl/core/atomic_memory_op_unit.sv
// Atomic memory operation unit: one read-modify-write per request.
// An accepted request is registered with its memory word; the execute state then
// writes the word back and registers the result, and no request is accepted until then.
// After reset, busy stays high while the memory is cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module atomic_memory_op_unit #(
  parameter int MEM_WORDS = 512
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  amo_pkg::amo_req_t in_req,
  output logic              out_valid,
  output amo_pkg::amo_rsp_t out_rsp
);
  import amo_pkg::*;

  localparam int IDX_W = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  amo_ctl_t         ctl;
  logic [IDX_W-1:0] clear_idx;

  amo_ctrl #(
    .MEM_WORDS (MEM_WORDS),
    .IDX_W     (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .ctl       (ctl),
    .clear_idx (clear_idx)
  );

  amo_dp #(
    .MEM_WORDS (MEM_WORDS),
    .IDX_W     (IDX_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .clear_idx (clear_idx),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

endmodule

>>> bench/atomic_memory_op_unit_test.sv
// Self-checking bench for atomic_memory_op_unit: directed then random requests,
// each predicted against a shadow copy of the word memory and checked in order.
// Depends on amo_pkg and the atomic_memory_op_unit RTL.
module atomic_memory_op_unit_test;
  import amo_pkg::*;

  localparam int MEM_WORDS = 512;
  localparam int RANDOM_REQS = 530;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [3:0] CMD_TOP_CODE = 4'd15;

  typedef struct {
    amo_req_t    req;
    int unsigned gap;
    bit          drain;
  } queued_req_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  amo_req_t in_req = '0;
  logic     out_valid;
  amo_rsp_t out_rsp;

  queued_req_t req_backlog[$];
  amo_rsp_t    expected_rsps[$];
  logic [63:0] shadow_mem [MEM_WORDS];
  logic [63:0] plan_mem [MEM_WORDS];
  int unsigned idle_count = 0;
  int unsigned quiet_cycles = 0;
  bit          failed = 1'b0;
  amo_rsp_t    mon_want;
  logic [63:0] mon_word;
  int unsigned mon_idx;

  atomic_memory_op_unit #(
    .MEM_WORDS(MEM_WORDS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit size_ok(logic [3:0] size);
    return size == SIZE_1 || size == SIZE_2 || size == SIZE_4 || size == SIZE_8;
  endfunction

  function automatic logic [63:0] size_mask(logic [3:0] size);
    case (size)
      SIZE_1: return 64'h0000_0000_0000_00FF;
      SIZE_2: return 64'h0000_0000_0000_FFFF;
      SIZE_4: return 64'h0000_0000_FFFF_FFFF;
      default: return '1;
    endcase
  endfunction

  function automatic int unsigned word_index(logic [11:0] addr);
    return int'(addr[11:3]) % MEM_WORDS;
  endfunction

  // Apply one read-modify-write to the containing word; return the response.
  function automatic amo_rsp_t atomic_update(input logic [63:0] word, input amo_req_t req,
                                             output logic [63:0] new_word);
    logic [63:0] mask;
    logic [63:0] opnd;
    logic [63:0] cmpv;
    logic [63:0] old_val;
    logic [63:0] next_val;
    logic [63:0] ret_val;
    logic [63:0] flip;
    int unsigned shift;
    amo_rsp_t    rsp;
    rsp.result = '0;
    new_word = word;
    if (!size_ok(req.size_bytes)) begin
      rsp.status = ST_BAD_SIZE;
      return rsp;
    end
    if ((req.address & ({8'd0, req.size_bytes} - 12'd1)) != 12'd0) begin
      rsp.status = ST_MISALIGN;
      return rsp;
    end
    if (req.command > CMD_UMIN) begin
      rsp.status = ST_BAD_CMD;
      return rsp;
    end
    mask = size_mask(req.size_bytes);
    opnd = req.operand & mask;
    cmpv = req.expected & mask;
    shift = 8 * int'(req.address[2:0]);
    old_val = (word >> shift) & mask;
    // flip the sign bit so that unsigned compare orders signed values
    flip = 64'd1 << (8 * int'(req.size_bytes) - 1);
    case (req.command)
      CMD_SWAP: begin
        next_val = opnd;
        ret_val = old_val;
      end
      CMD_CAS: begin
        if (old_val == cmpv) begin
          next_val = opnd;
          ret_val = 64'd0;
        end else begin
          next_val = old_val;
          ret_val = 64'd1;
        end
      end
      CMD_ADD: begin
        next_val = old_val + opnd;
        ret_val = old_val;
      end
      CMD_SUB: begin
        next_val = old_val - opnd;
        ret_val = old_val;
      end
      CMD_AND: begin
        next_val = old_val & opnd;
        ret_val = old_val;
      end
      CMD_OR: begin
        next_val = old_val | opnd;
        ret_val = old_val;
      end
      CMD_XOR: begin
        next_val = old_val ^ opnd;
        ret_val = old_val;
      end
      CMD_SMAX: begin
        next_val = ((old_val ^ flip) < (opnd ^ flip)) ? opnd : old_val;
        ret_val = next_val;
      end
      CMD_SMIN: begin
        next_val = ((opnd ^ flip) < (old_val ^ flip)) ? opnd : old_val;
        ret_val = next_val;
      end
      CMD_UMAX: begin
        next_val = (opnd > old_val) ? opnd : old_val;
        ret_val = next_val;
      end
      default: begin
        next_val = (opnd < old_val) ? opnd : old_val;
        ret_val = next_val;
      end
    endcase
    next_val = next_val & mask;
    new_word = (word & ~(mask << shift)) | (next_val << shift);
    rsp.result = ret_val & mask;
    rsp.status = ST_OK;
    return rsp;
  endfunction

  function automatic amo_req_t make_req(logic [3:0] cmd, logic [11:0] addr, logic [3:0] size,
                                        logic [63:0] opnd, logic [63:0] cmpv);
    amo_req_t req;
    req.command = cmd;
    req.address = addr;
    req.size_bytes = size;
    req.operand = opnd;
    req.expected = cmpv;
    return req;
  endfunction

  // Field value that the planned request stream leaves at this address.
  function automatic logic [63:0] planned_value(logic [11:0] addr, logic [3:0] size);
    return (plan_mem[word_index(addr)] >> (8 * int'(addr[2:0]))) & size_mask(size);
  endfunction

  function automatic void plan_request(amo_req_t req, int unsigned gap, bit drain);
    logic [63:0] word;
    int unsigned idx;
    idx = word_index(req.address);
    void'(atomic_update(plan_mem[idx], req, word));
    plan_mem[idx] = word;
    req_backlog.push_back('{req, gap, drain});
  endfunction

  function automatic logic [3:0] random_size(bit wide_only);
    case (wide_only ? $urandom_range(3, 1) : $urandom_range(3))
      0: return SIZE_1;
      1: return SIZE_2;
      2: return SIZE_4;
      default: return SIZE_8;
    endcase
  endfunction

  function automatic logic [63:0] random_operand(logic [3:0] size);
    case ($urandom_range(4))
      0: return 64'($urandom_range(15));
      1: return '1;
      2: return (64'd1 << (8 * int'(size) - 1)) - 64'($urandom_range(1));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic bit results_settled();
    return expected_rsps.size() == 0 && !out_valid && !start;
  endfunction

  // Request driver: hold a request until accepted, then advance the backlog.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      idle_count <= 0;
    end else if (!start || !busy) begin
      if (req_backlog.size() != 0 && idle_count >= req_backlog[0].gap &&
          (!req_backlog[0].drain || results_settled())) begin
        start <= 1'b1;
        in_req <= req_backlog[0].req;
        idle_count <= 0;
        req_backlog.delete(0);
      end else begin
        start <= 1'b0;
        if (req_backlog.size() != 0 && idle_count < req_backlog[0].gap) begin
          idle_count <= idle_count + 1;
        end
      end
    end
  end

  // Response monitor, shadow memory update and watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (expected_rsps.size() == 0) begin
          $error("result with no request pending: result %h status %0d",
                 out_rsp.result, out_rsp.status);
          failed = 1'b1;
        end else begin
          mon_want = expected_rsps.pop_front();
          if (out_rsp.result !== mon_want.result) begin
            $error("result mismatch: expected %h, actual %h", mon_want.result, out_rsp.result);
            failed = 1'b1;
          end
          if (out_rsp.status !== mon_want.status) begin
            $error("status mismatch: expected %0d, actual %0d", mon_want.status, out_rsp.status);
            failed = 1'b1;
          end
        end
      end
      if (start && !busy) begin
        mon_idx = word_index(in_req.address);
        expected_rsps.push_back(atomic_update(shadow_mem[mon_idx], in_req, mon_word));
        shadow_mem[mon_idx] = mon_word;
      end
    end
    if (out_valid || (start && !busy)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
  end

  initial begin
    logic [3:0]  cmd;
    logic [3:0]  size;
    logic [11:0] addr;
    logic [63:0] opnd;
    logic [63:0] cmpv;
    int unsigned pick;
    int unsigned gap;
    for (int i = 0; i < MEM_WORDS; i++) begin
      shadow_mem[i] = '0;
      plan_mem[i] = '0;
    end

    // Directed: every command, width and address extremes, each error status.
    plan_request(make_req(CMD_SWAP, 12'd0, SIZE_8, '1, '1), 0, 0);
    plan_request(make_req(CMD_SWAP, 12'd8, SIZE_8, 64'h8000_0000_0000_0001, '0), 0, 0);
    plan_request(make_req(CMD_ADD, 12'd0, SIZE_8, 64'd1, '0), 1, 0);
    plan_request(make_req(CMD_SUB, 12'd0, SIZE_8, 64'd1, '0), 0, 0);
    plan_request(make_req(CMD_AND, 12'd4, SIZE_4, 64'hFFFF_FFFF_0F0F_0F0F, '0), 0, 0);
    plan_request(make_req(CMD_OR, 12'd2, SIZE_2, 64'h0000_0000_0000_A5A5, '0), 2, 0);
    plan_request(make_req(CMD_XOR, 12'd1, SIZE_1, '1, '0), 0, 0);
    plan_request(make_req(CMD_CAS, 12'd8, SIZE_8, 64'h1234,
                          planned_value(12'd8, SIZE_8)), 0, 0);
    plan_request(make_req(CMD_CAS, 12'd8, SIZE_8, '1, '0), 0, 0);
    plan_request(make_req(CMD_CAS, 12'd2, SIZE_2, 64'h5A5A,
                          planned_value(12'd2, SIZE_2) | 64'hFFFF_FFFF_FFFF_0000), 0, 0);
    plan_request(make_req(CMD_SMAX, 12'd16, SIZE_1, 64'h80, '0), 0, 0);
    plan_request(make_req(CMD_SMIN, 12'd16, SIZE_1, 64'h80, '0), 0, 0);
    plan_request(make_req(CMD_SMAX, 12'd18, SIZE_2, 64'h7FFF, '0), 0, 0);
    plan_request(make_req(CMD_UMAX, 12'd20, SIZE_4, 64'hFFFF_FFFF, '0), 3, 0);
    plan_request(make_req(CMD_UMIN, 12'd20, SIZE_4, 64'd0, '0), 0, 0);
    plan_request(make_req(CMD_SMIN, 12'd24, SIZE_8, 64'h8000_0000_0000_0000, '0), 0, 0);
    plan_request(make_req(CMD_SMAX, 12'd24, SIZE_8, 64'h7FFF_FFFF_FFFF_FFFF, '0), 0, 0);
    plan_request(make_req(CMD_SWAP, 12'd4095, SIZE_1, '1, '1), 0, 0);
    plan_request(make_req(CMD_ADD, 12'd4088, SIZE_8, '1, '1), 0, 0);
    // bad size wins over misalignment and a bad command
    plan_request(make_req(CMD_SWAP, 12'd0, 4'd0, '1, '1), 0, 0);
    plan_request(make_req(CMD_TOP_CODE, 12'd1, 4'd3, '1, '1), 0, 0);
    plan_request(make_req(CMD_ADD, 12'd0, 4'd15, '1, '1), 0, 0);
    // misalignment wins over a bad command
    plan_request(make_req(CMD_ADD, 12'd4, SIZE_8, '1, '1), 0, 0);
    plan_request(make_req(CMD_TOP_CODE, 12'd4095, SIZE_2, '1, '1), 0, 0);
    plan_request(make_req(CMD_UMIN + 4'd1, 12'd8, SIZE_8, '1, '1), 0, 0);
    plan_request(make_req(CMD_TOP_CODE, 12'd3, SIZE_1, '1, '1), 0, 0);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      pick = $urandom_range(99);
      size = random_size(1'b0);
      cmd = 4'($urandom_range(CMD_UMIN));
      // keep most traffic on a few words so values build up
      if ($urandom_range(3) != 0) begin
        addr = 12'($urandom_range(7)) << 3;
      end else begin
        addr = 12'($urandom_range(MEM_WORDS - 1)) << 3;
      end
      addr = addr | (12'($urandom_range(7)) & ~({8'd0, size} - 12'd1));
      opnd = random_operand(size);
      cmpv = {$urandom, $urandom};
      if (cmd == CMD_CAS && $urandom_range(2) != 0) begin
        cmpv = planned_value(addr, size) | (cmpv & ~size_mask(size));
      end
      if (pick < 5) begin
        do size = 4'($urandom_range(15)); while (size_ok(size));
      end else if (pick < 10) begin
        size = random_size(1'b1);
        addr = 12'($urandom_range(4095));
        if ((addr & ({8'd0, size} - 12'd1)) == 12'd0) addr[0] = 1'b1;
      end else if (pick < 14) begin
        cmd = 4'($urandom_range(CMD_TOP_CODE, CMD_UMIN + 4'd1));
      end
      gap = $urandom_range(99);
      if (i >= 200 && i < 280) begin
        gap = 0;
      end else if (gap < 60) begin
        gap = 0;
      end else if (gap < 92) begin
        gap = $urandom_range(3, 1);
      end else begin
        gap = $urandom_range(40, 10);
      end
      plan_request(make_req(cmd, addr, size, opnd, cmpv), gap, i % 150 == 0);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (req_backlog.size() != 0 || start) @(negedge clk);
    while (expected_rsps.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
